[sv/ppts_pkg.sv]
// Shared constants and register codes for the perspective projection core.
`default_nettype none

package ppts_pkg;

	// Configuration port geometry
	localparam int CFG_W     = 64;
	localparam int REG_IDX_W = 3;
	localparam int MAT_W     = 32;
	localparam int SIZE_W    = 16;
	localparam int ACC_W     = 64;
	localparam int TERM_W    = 60;

	// Each product term clamps to this magnitude
	localparam logic [127:0] TERM_MAX = 128'(1) << 59;

	// Screen size after reset
	localparam logic [SIZE_W-1:0] WIDTH_RST  = 16'd1920;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 16'd1080;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ROW0_A   = 3'd0,
		REG_ROW0_B   = 3'd1,
		REG_ROW1_A   = 3'd2,
		REG_ROW1_B   = 3'd3,
		REG_ROW3_A   = 3'd4,
		REG_ROW3_B   = 3'd5,
		REG_S_WIDTH  = 3'd6,
		REG_S_HEIGHT = 3'd7
	} cfg_idx_t;

endpackage

`default_nettype wire

[sv/perspective_project_to_screen_core.sv]
// Pipelined world-to-screen perspective projection core.
`default_nettype none

// Projects one world point per cycle, unless stalled, through matrix rows 0, 1 and 3 and
// maps the result to pixel coordinates. The pipeline is COORD_WIDTH + 6 stages deep: one
// stage of product multipliers, one of row sums, one of clip setup, one of screen scaling,
// one of overflow check, COORD_WIDTH restoring division stages (one quotient bit each
// per axis) and the output register. Throughput is one point per cycle when the output
// does not stall. Each stage holds its own valid bit, so a stall at the output only backs
// up stages that already hold a transaction and bubbles are squeezed out. Write
// configuration only while the pipeline is empty.
module perspective_project_to_screen_core #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [ppts_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [ppts_pkg::CFG_W-1:0]         wr_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [COORD_WIDTH-1:0]      world_x,
	input  logic signed [COORD_WIDTH-1:0]      world_y,
	input  logic signed [COORD_WIDTH-1:0]      world_z,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               visible,
	output logic signed [COORD_WIDTH-1:0]      screen_x,
	output logic signed [COORD_WIDTH-1:0]      screen_y
);
	import ppts_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int PW = MAT_W + CW;
	localparam int NW = 80 + FRAC_BITS + CW;
	localparam longint THR_RAW = ((longint'(1) << FRAC_BITS) + 500) / 1000;
	localparam logic signed [ACC_W-1:0] W_THR = (THR_RAW < 1) ? 64'sd1 : ACC_W'(THR_RAW);

	// ---------------- configuration registers ----------------
	logic [CFG_W-1:0]  mat_q [6];
	logic [SIZE_W-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) mat_q[i] <= '0;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				REG_ROW0_A:   mat_q[0] <= wr_data;
				REG_ROW0_B:   mat_q[1] <= wr_data;
				REG_ROW1_A:   mat_q[2] <= wr_data;
				REG_ROW1_B:   mat_q[3] <= wr_data;
				REG_ROW3_A:   mat_q[4] <= wr_data;
				REG_ROW3_B:   mat_q[5] <= wr_data;
				REG_S_WIDTH:  width_q  <= wr_data[SIZE_W-1:0];
				REG_S_HEIGHT: height_q <= wr_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Split register pairs into signed matrix entries
	logic signed [MAT_W-1:0] me [12];
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			me[2*i]   = mat_q[i][MAT_W-1:0];
			me[2*i+1] = mat_q[i][CFG_W-1:MAT_W];
		end
	end

	// ---------------- stage valids and ready chain ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s7;
	logic v_s6 [CW];
	logic r_s1, r_s2, r_s3, r_s4, r_s5, r_s7;
	logic r_s6 [CW];

	assign r_s7 = !v_s7 || !out_stall;
	genvar g;
	generate
		for (g = 0; g < CW; g++) begin : g_rdy
			if (g == CW - 1) begin : g_last
				assign r_s6[g] = !v_s6[g] || r_s7;
			end else begin : g_mid
				assign r_s6[g] = !v_s6[g] || r_s6[g+1];
			end
		end
	endgenerate
	assign r_s5 = !v_s5 || r_s6[0];
	assign r_s4 = !v_s4 || r_s5;
	assign r_s3 = !v_s3 || r_s4;
	assign r_s2 = !v_s2 || r_s3;
	assign r_s1 = !v_s1 || r_s2;
	assign in_stall = !r_s1;

	// ---------------- stage 1: term products ----------------
	logic [CW-1:0]    cmag [3];
	logic             csgn [3];
	logic [PW-1:0]    prod_c [9];
	logic             pneg_c [9];
	logic [PW-1:0]    prod_s1 [9];
	logic             pneg_s1 [9];

	always_comb begin
		cmag[0] = world_x[CW-1] ? CW'(-world_x) : CW'(world_x);
		cmag[1] = world_y[CW-1] ? CW'(-world_y) : CW'(world_y);
		cmag[2] = world_z[CW-1] ? CW'(-world_z) : CW'(world_z);
		csgn[0] = world_x[CW-1];
		csgn[1] = world_y[CW-1];
		csgn[2] = world_z[CW-1];
	end

	generate
		for (g = 0; g < 9; g++) begin : g_prod
			localparam int E = 4 * (g / 3) + (g % 3);
			logic [MAT_W-1:0] mmag;
			assign mmag      = me[E][MAT_W-1] ? MAT_W'(-me[E]) : MAT_W'(me[E]);
			assign prod_c[g] = PW'(mmag) * PW'(cmag[g % 3]);
			assign pneg_c[g] = me[E][MAT_W-1] ^ csgn[g % 3];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (r_s1) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (r_s1 && in_valid) begin
			for (int j = 0; j < 9; j++) begin
				prod_s1[j] <= prod_c[j];
				pneg_s1[j] <= pneg_c[j];
			end
		end
	end

	// ---------------- stage 2: clamp terms and sum rows ----------------
	logic signed [ACC_W-1:0] term_c [9];
	logic signed [ACC_W-1:0] acc_c  [3];
	logic signed [ACC_W-1:0] acc_s2 [3];

	always_comb begin
		logic [127:0]        sh;
		logic [TERM_W-1:0]   cl;
		logic signed [ACC_W-1:0] tv;
		for (int j = 0; j < 9; j++) begin
			sh = 128'(prod_s1[j] >> FRAC_BITS);
			cl = (sh > TERM_MAX) ? TERM_MAX[TERM_W-1:0] : sh[TERM_W-1:0];
			tv = ACC_W'(cl);
			term_c[j] = pneg_s1[j] ? -tv : tv;
		end
		for (int r = 0; r < 3; r++) begin
			acc_c[r] = term_c[3*r] + term_c[3*r+1] + term_c[3*r+2]
				+ ACC_W'(me[4*r+3]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (r_s2) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (r_s2 && v_s1) begin
			for (int r = 0; r < 3; r++) acc_s2[r] <= acc_c[r];
		end
	end

	// ---------------- stage 3: visibility, numerators, divisor ----------------
	logic signed [ACC_W-1:0] numx_c, numy_c;
	logic                    vis_s3, negx_s3, negy_s3;
	logic [ACC_W-1:0]        magx_s3, magy_s3, d_s3;

	assign numx_c = acc_s2[0] + acc_s2[2];
	assign numy_c = acc_s2[2] - acc_s2[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (r_s3) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (r_s3 && v_s2) begin
			vis_s3  <= acc_s2[2] >= W_THR;
			negx_s3 <= numx_c[ACC_W-1];
			negy_s3 <= numy_c[ACC_W-1];
			magx_s3 <= numx_c[ACC_W-1] ? ACC_W'(-numx_c) : ACC_W'(numx_c);
			magy_s3 <= numy_c[ACC_W-1] ? ACC_W'(-numy_c) : ACC_W'(numy_c);
			d_s3    <= {acc_s2[2][ACC_W-2:0], 1'b0};
		end
	end

	// ---------------- stage 4: scale numerators by screen size ----------------
	logic [79:0]      px_c, py_c;
	logic [NW-1:0]    nx_s4, ny_s4;
	logic [ACC_W-1:0] d_s4;
	logic             vis_s4, negx_s4, negy_s4;

	assign px_c = 80'(magx_s3) * 80'(width_q);
	assign py_c = 80'(magy_s3) * 80'(height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (r_s4) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (r_s4 && v_s3) begin
			nx_s4   <= NW'(px_c) << FRAC_BITS;
			ny_s4   <= NW'(py_c) << FRAC_BITS;
			d_s4    <= d_s3;
			vis_s4  <= vis_s3;
			negx_s4 <= negx_s3;
			negy_s4 <= negy_s3;
		end
	end

	// ---------------- stage 5: quotient overflow check ----------------
	logic [NW-1:0] dtop_c;
	logic [NW-1:0] remx_s5, remy_s5;
	logic [ACC_W-1:0] d_s5;
	logic vis_s5, negx_s5, negy_s5, ovfx_s5, ovfy_s5;

	assign dtop_c = NW'(d_s4) << CW;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (r_s5) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (r_s5 && v_s4) begin
			remx_s5 <= nx_s4;
			remy_s5 <= ny_s4;
			ovfx_s5 <= nx_s4 >= dtop_c;
			ovfy_s5 <= ny_s4 >= dtop_c;
			d_s5    <= d_s4;
			vis_s5  <= vis_s4;
			negx_s5 <= negx_s4;
			negy_s5 <= negy_s4;
		end
	end

	// ---------------- stage 6 group: one quotient bit per stage ----------------
	logic [NW-1:0]    remx_s6 [CW], remy_s6 [CW];
	logic [CW-1:0]    qx_s6 [CW], qy_s6 [CW];
	logic [ACC_W-1:0] d_s6 [CW];
	logic             vis_s6 [CW], negx_s6 [CW], negy_s6 [CW];
	logic             ovfx_s6 [CW], ovfy_s6 [CW];

	generate
		for (g = 0; g < CW; g++) begin : g_div
			localparam int B = CW - 1 - g;
			logic             pv;
			logic [NW-1:0]    prx, pry, trial;
			logic [CW-1:0]    pqx, pqy;
			logic [ACC_W-1:0] pd;
			logic             pvis, pnx, pny, pox, poy;
			if (g == 0) begin : g_first
				assign pv = v_s5;   assign prx = remx_s5; assign pry = remy_s5;
				assign pqx = '0;    assign pqy = '0;      assign pd = d_s5;
				assign pvis = vis_s5; assign pnx = negx_s5; assign pny = negy_s5;
				assign pox = ovfx_s5; assign poy = ovfy_s5;
			end else begin : g_next
				assign pv = v_s6[g-1];   assign prx = remx_s6[g-1];
				assign pry = remy_s6[g-1]; assign pqx = qx_s6[g-1];
				assign pqy = qy_s6[g-1]; assign pd = d_s6[g-1];
				assign pvis = vis_s6[g-1]; assign pnx = negx_s6[g-1];
				assign pny = negy_s6[g-1]; assign pox = ovfx_s6[g-1];
				assign poy = ovfy_s6[g-1];
			end
			assign trial = NW'(pd) << B;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) v_s6[g] <= 1'b0;
				else if (r_s6[g]) v_s6[g] <= pv;
			end
			// Subtract the shifted divisor where it fits, set the quotient bit
			always_ff @(posedge clk) begin
				if (r_s6[g] && pv) begin
					if (prx >= trial) begin
						remx_s6[g] <= prx - trial;
						qx_s6[g]   <= pqx | (CW'(1) << B);
					end else begin
						remx_s6[g] <= prx;
						qx_s6[g]   <= pqx;
					end
					if (pry >= trial) begin
						remy_s6[g] <= pry - trial;
						qy_s6[g]   <= pqy | (CW'(1) << B);
					end else begin
						remy_s6[g] <= pry;
						qy_s6[g]   <= pqy;
					end
					d_s6[g]    <= pd;
					vis_s6[g]  <= pvis;
					negx_s6[g] <= pnx;
					negy_s6[g] <= pny;
					ovfx_s6[g] <= pox;
					ovfy_s6[g] <= poy;
				end
			end
		end
	endgenerate

	// ---------------- stage 7: saturate, sign and output register ----------------
	localparam logic [CW-1:0] HALF = CW'(1) << (CW - 1);
	logic [CW-1:0] limx_c, limy_c, satx_c, saty_c;
	logic          vis_c;
	logic          vis_s7;
	logic [CW-1:0] sx_s7, sy_s7;

	assign vis_c  = vis_s6[CW-1];
	assign limx_c = negx_s6[CW-1] ? HALF : HALF - CW'(1);
	assign limy_c = negy_s6[CW-1] ? HALF : HALF - CW'(1);
	assign satx_c = (ovfx_s6[CW-1] || qx_s6[CW-1] > limx_c) ? limx_c : qx_s6[CW-1];
	assign saty_c = (ovfy_s6[CW-1] || qy_s6[CW-1] > limy_c) ? limy_c : qy_s6[CW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (r_s7) v_s7 <= v_s6[CW-1];
	end
	always_ff @(posedge clk) begin
		if (r_s7 && v_s6[CW-1]) begin
			vis_s7 <= vis_c;
			sx_s7  <= !vis_c ? '0 : (negx_s6[CW-1] ? -satx_c : satx_c);
			sy_s7  <= !vis_c ? '0 : (negy_s6[CW-1] ? -saty_c : saty_c);
		end
	end

	assign out_valid = v_s7;
	assign visible   = vis_s7;
	assign screen_x  = sx_s7;
	assign screen_y  = sy_s7;

	// ---------------- assertions ----------------
	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !visible |-> screen_x == '0 && screen_y == '0)
		else $error("hidden point with nonzero coordinates");

	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s7 |-> !in_stall)
		else $error("input stalled while output stage empty");

	a_div_floor: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && vis_s3 |-> d_s3 >= ACC_W'(W_THR) && !d_s3[0])
		else $error("divisor below visibility threshold");

endmodule

`default_nettype wire
